// File: rtl/ssgcr_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment glyph column raster package
// Shared types, constants and glyph helper functions.
// ----------------------------------------------------------------------------
package ssgcr_pkg;

  localparam int unsigned MaxSize  = 64;
  localparam int unsigned DivSteps = 7;
  localparam int unsigned NumSegs  = 8;
  localparam int unsigned RowsPerByte = 8;

  localparam int unsigned AddrWidth = 3;
  localparam logic CFG_IDX_DIVISOR = 1'b0;
  localparam logic [6:0] DIVISOR_RESET = 7'd4;

  localparam logic [2:0] SEG_A = 3'd0;
  localparam logic [2:0] SEG_B = 3'd1;
  localparam logic [2:0] SEG_C = 3'd2;
  localparam logic [2:0] SEG_D = 3'd3;
  localparam logic [2:0] SEG_E = 3'd4;
  localparam logic [2:0] SEG_F = 3'd5;
  localparam logic [2:0] SEG_G = 3'd6;
  localparam logic [2:0] SEG_P = 3'd7;

  localparam logic [1:0] BOX_NONE   = 2'd0;
  localparam logic [1:0] BOX_FIRST  = 2'd1;
  localparam logic [1:0] BOX_SECOND = 2'd2;
  localparam logic [1:0] BOX_THIRD  = 2'd3;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_UP,
    DIR_LEFT,
    DIR_DOWN
  } dir_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic setup;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic empty;
    logic last_byte;
    logic out_free;
  } dp_sts_t;

  function automatic logic [6:0] glyph_segs(logic [3:0] idx);
    logic [6:0] segs;
    case (idx)
      4'h0: segs = 7'h3F;
      4'h1: segs = 7'h06;
      4'h2: segs = 7'h5B;
      4'h3: segs = 7'h4F;
      4'h4: segs = 7'h66;
      4'h5: segs = 7'h6D;
      4'h6: segs = 7'h7D;
      4'h7: segs = 7'h07;
      4'h8: segs = 7'h7F;
      4'h9: segs = 7'h6F;
      4'hA: segs = 7'h77;
      4'hB: segs = 7'h7C;
      4'hC: segs = 7'h39;
      4'hD: segs = 7'h5E;
      4'hE: segs = 7'h79;
      4'hF: segs = 7'h71;
      default: segs = 7'h00;
    endcase
    return segs;
  endfunction

  function automatic dir_e tri_dir(logic [7:0] ax, logic [7:0] ay, logic [6:0] tkn);
    logic signed [9:0] diff;
    logic signed [9:0] ays;
    diff = signed'({3'b000, tkn}) - signed'({2'b00, ax});
    ays  = signed'({2'b00, ay});
    if (ax >= ay) begin
      return (diff > ays) ? DIR_DOWN : DIR_LEFT;
    end
    return (diff > ays) ? DIR_RIGHT : DIR_UP;
  endfunction

  function automatic logic tri_owned(logic [2:0] s, dir_e dir, logic [1:0] bx, logic [1:0] by);
    logic hseg;
    logic own;
    hseg = (s == SEG_A) || (s == SEG_G) || (s == SEG_D);
    own  = 1'b0;
    if (bx == BOX_FIRST) begin
      own = ((dir == DIR_LEFT) && hseg) ||
            ((dir == DIR_UP) && (((s == SEG_E) && (by == BOX_FIRST)) ||
                                 ((s == SEG_F) && (by == BOX_SECOND)))) ||
            ((dir == DIR_DOWN) && (((s == SEG_E) && (by == BOX_SECOND)) ||
                                   ((s == SEG_F) && (by == BOX_THIRD))));
    end else if (bx == BOX_SECOND) begin
      own = ((dir == DIR_RIGHT) && hseg) ||
            ((dir == DIR_UP) && (((s == SEG_C) && (by == BOX_FIRST)) ||
                                 ((s == SEG_B) && (by == BOX_SECOND)))) ||
            ((dir == DIR_DOWN) && (((s == SEG_C) && (by == BOX_SECOND)) ||
                                   ((s == SEG_B) && (by == BOX_THIRD))));
    end
    return own;
  endfunction

endpackage

// File: rtl/ssgcr_if.sv
// ----------------------------------------------------------------------------
// Seven-segment glyph column raster channels
// Valid/ready channels for the column requests and the pixel bytes.
// ----------------------------------------------------------------------------
interface ssgcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] origin_x;
  logic [7:0] origin_y;
  logic [6:0] digit_size;
  logic [7:0] digit_code;
  logic [6:0] column;

  modport source (output valid, origin_x, origin_y, digit_size, digit_code, column,
                  input ready);
  modport sink (input valid, origin_x, origin_y, digit_size, digit_code, column,
                output ready);
endinterface

interface ssgcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] pixel_byte;
  logic       last;

  modport source (output valid, pos_x, pos_y, pixel_byte, last, input ready);
  modport sink (input valid, pos_x, pos_y, pixel_byte, last, output ready);
endinterface

// File: rtl/ssgcr_ctrl.sv
// ----------------------------------------------------------------------------
// Seven-segment glyph column raster controller
// Sequences accept, thickness divide, box setup and byte emission.
// ----------------------------------------------------------------------------
module ssgcr_ctrl
  import ssgcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = sts_i.empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_byte) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ssgcr_datapath.sv
// ----------------------------------------------------------------------------
// Seven-segment glyph column raster datapath
// Serial thickness divider, segment box setup, eight parallel row tests and
// the output byte register.
// ----------------------------------------------------------------------------
module ssgcr_datapath
  import ssgcr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_sts_t            sts_o,
  input  logic [6:0]         divisor_i,
  input  logic [7:0]         origin_x_i,
  input  logic [7:0]         origin_y_i,
  input  logic [6:0]         digit_size_i,
  input  logic [7:0]         digit_code_i,
  input  logic [6:0]         column_i,
  ssgcr_out_if.source        out_o
);

  logic [7:0] ox_q, oy_q, segs_q;
  logic [6:0] size_q, x_q;
  logic [7:0] rem_q;
  logic [6:0] quo_q;
  logic [2:0] cnt_q;

  logic [6:0] tkn_q;
  logic [7:0] segx_q;
  logic [1:0] bx_q;
  logic [7:0] ax_q;
  logic [7:0] my1lo_q, my1hi_q, my2lo_q;
  logic       miter_q;
  logic [7:0] ymin_q [NumSegs];
  logic [7:0] ymax_q [NumSegs];
  logic [2:0] byte_q;

  logic       out_valid_q;
  logic [7:0] pos_x_q, pos_y_q, pix_q;
  logic       last_q;

  logic [6:0] size_sat;
  logic [6:0] div_eff;
  logic [7:0] trial;
  logic       trial_ge;

  logic [6:0] tkn_c;
  logic [7:0] size8, w8, t8, h8, x8;
  logic [8:0] col_lim;
  logic [7:0] xmin_c [NumSegs];
  logic [7:0] xmax_c [NumSegs];
  logic [7:0] ymin_c [NumSegs];
  logic [7:0] ymax_c [NumSegs];
  logic [7:0] xin_c;
  logic [7:0] mx1_c;
  logic [1:0] bx_c;
  logic [7:0] ax_c;

  logic [7:0] lit;
  logic [7:0] qsize8, qtkn8;
  logic       partial;

  assign size_sat = (digit_size_i > 7'(MaxSize)) ? 7'(MaxSize) : digit_size_i;
  assign div_eff  = (divisor_i == 7'd0) ? 7'd1 : divisor_i;
  assign trial    = {rem_q[6:0], quo_q[6]};
  assign trial_ge = trial >= {1'b0, div_eff};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ox_q   <= origin_x_i;
      oy_q   <= origin_y_i;
      size_q <= size_sat;
      segs_q <= {digit_code_i[7], glyph_segs(digit_code_i[3:0])};
      x_q    <= column_i;
      rem_q  <= 8'd0;
      quo_q  <= size_sat;
      cnt_q  <= 3'd0;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? (trial - {1'b0, div_eff}) : trial;
      quo_q <= {quo_q[5:0], trial_ge};
      cnt_q <= cnt_q + 3'd1;
    end
  end

  assign tkn_c   = (quo_q == 7'd0) ? 7'd1 : quo_q;
  assign size8   = {1'b0, size_q};
  assign w8      = {2'b00, size_q[6:1]};
  assign t8      = {1'b0, tkn_c};
  assign h8      = {2'b00, tkn_c[6:1]};
  assign x8      = {1'b0, x_q};
  assign mx1_c   = w8 - t8;
  assign col_lim = {1'b0, w8} + {1'b0, t8} + 9'd2;

  always_comb begin
    xmin_c[SEG_A] = 8'd0;       xmax_c[SEG_A] = w8;
    ymin_c[SEG_A] = size8 - t8; ymax_c[SEG_A] = size8;
    xmin_c[SEG_B] = w8 - t8;    xmax_c[SEG_B] = w8;
    ymin_c[SEG_B] = w8;         ymax_c[SEG_B] = size8;
    xmin_c[SEG_C] = w8 - t8;    xmax_c[SEG_C] = w8;
    ymin_c[SEG_C] = 8'd0;       ymax_c[SEG_C] = w8;
    xmin_c[SEG_D] = 8'd0;       xmax_c[SEG_D] = w8;
    ymin_c[SEG_D] = 8'd0;       ymax_c[SEG_D] = t8;
    xmin_c[SEG_E] = 8'd0;       xmax_c[SEG_E] = t8;
    ymin_c[SEG_E] = 8'd0;       ymax_c[SEG_E] = w8;
    xmin_c[SEG_F] = 8'd0;       xmax_c[SEG_F] = t8;
    ymin_c[SEG_F] = w8;         ymax_c[SEG_F] = size8;
    xmin_c[SEG_G] = 8'd0;       xmax_c[SEG_G] = w8;
    ymin_c[SEG_G] = w8 - h8;    ymax_c[SEG_G] = w8 + t8 - h8;
    xmin_c[SEG_P] = w8 + 8'd1;  xmax_c[SEG_P] = t8 + w8 + 8'd2;
    ymin_c[SEG_P] = 8'd0;       ymax_c[SEG_P] = t8;
    for (int s = 0; s < NumSegs; s++) begin
      xin_c[s] = (xmin_c[s] <= x8) && (xmax_c[s] > x8);
    end
    bx_c = BOX_NONE;
    ax_c = 8'd0;
    if (x8 < t8) begin
      bx_c = BOX_FIRST;
      ax_c = x8;
    end else if ((x8 >= mx1_c) && (x8 < w8)) begin
      bx_c = BOX_SECOND;
      ax_c = x8 - mx1_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      tkn_q   <= tkn_c;
      segx_q  <= segs_q & xin_c;
      bx_q    <= bx_c;
      ax_q    <= ax_c;
      my1lo_q <= w8 - h8;
      my1hi_q <= w8 + t8 - h8;
      my2lo_q <= size8 - t8;
      miter_q <= size_q >= 7'd16;
      ymin_q  <= ymin_c;
      ymax_q  <= ymax_c;
    end
  end

  assign qsize8 = {1'b0, size_q};
  assign qtkn8  = {1'b0, tkn_q};

  for (genvar r = 0; r < RowsPerByte; r++) begin : g_row
    logic [7:0] y;
    logic [1:0] by;
    logic [7:0] ay;
    dir_e       dir;
    logic [7:0] hit;

    assign y = {2'b00, byte_q, 3'(r)};

    always_comb begin
      by = BOX_NONE;
      ay = 8'd0;
      if (bx_q != BOX_NONE) begin
        if (y < qtkn8) begin
          by = BOX_FIRST;
          ay = y;
        end else if ((y >= my1lo_q) && (y < my1hi_q)) begin
          by = BOX_SECOND;
          ay = y - my1lo_q;
        end else if ((y >= my2lo_q) && (y < qsize8)) begin
          by = BOX_THIRD;
          ay = y - my2lo_q;
        end
      end
    end

    assign dir = tri_dir(ax_q, ay, tkn_q);

    for (genvar s = 0; s < NumSegs; s++) begin : g_seg
      assign hit[s] = segx_q[s] && (ymin_q[s] <= y) && (ymax_q[s] > y) &&
                      (!miter_q || (bx_q == BOX_NONE) || (by == BOX_NONE) ||
                       tri_owned(3'(s), dir, bx_q, by));
    end

    assign lit[RowsPerByte - 1 - r] = (y < qsize8) && (|hit);
  end

  assign partial = size_q[2:0] != 3'd0;

  assign sts_o.div_done  = cnt_q == 3'(DivSteps - 1);
  assign sts_o.empty     = (size_q == 7'd0) || ({1'b0, x8} >= col_lim);
  assign sts_o.last_byte = byte_q == 3'((size_q - 7'd1) >> 3);
  assign sts_o.out_free  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      byte_q <= 3'd0;
    end else if (cmd_i.emit) begin
      byte_q <= byte_q + 3'd1;
    end
    if (cmd_i.emit) begin
      pos_x_q <= ox_q + x8;
      pos_y_q <= (sts_o.last_byte && partial) ? (oy_q + qsize8)
                                              : (oy_q + {2'b00, byte_q, 3'b111});
      pix_q   <= lit;
      last_q  <= sts_o.last_byte;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pos_x      = pos_x_q;
  assign out_o.pos_y      = pos_y_q;
  assign out_o.pixel_byte = pix_q;
  assign out_o.last       = last_q;

endmodule

// File: rtl/seven_segment_glyph_column_raster_unit.sv
// ----------------------------------------------------------------------------
// Seven-segment glyph column raster unit
// Renders one pixel column of a scalable hex digit into row-packed bytes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake        Payload
//  in_i     sink       valid/ready      origin_x, origin_y, digit_size,
//                                       digit_code, column
//  out_o    source     valid/ready      pos_x, pos_y, pixel_byte, last
//  cfg      slave      APB write/read   thickness_divisor at byte addresses 0-3
//
//  An item is accepted, runs through the bit-serial thickness divider and
//  box setup, then yields ceil(size/8) bytes, one byte per cycle while
//  out_o is not stalled. An item with no bytes returns to idle after setup.
//  The output register holds each byte until it is taken; a stall on out_o
//  stops emission. The next item is accepted once the last byte is loaded.
//  Reset sets the divisor to 4 and empties the output register.
// ----------------------------------------------------------------------------
module seven_segment_glyph_column_raster_unit
  import ssgcr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ssgcr_in_if.sink             in_i,
  ssgcr_out_if.source          out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [6:0] divisor_q;
  logic       sel_divisor;
  ctrl_cmd_t  cmd;
  dp_sts_t    sts;

  assign sel_divisor = paddr[AddrWidth-1] == CFG_IDX_DIVISOR;
  assign pready      = 1'b1;
  assign prdata      = sel_divisor ? {25'd0, divisor_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= DIVISOR_RESET;
    end else if (psel && penable && pwrite && sel_divisor) begin
      divisor_q <= pwdata[6:0];
    end
  end

  ssgcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssgcr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .divisor_i    (divisor_q),
    .origin_x_i   (in_i.origin_x),
    .origin_y_i   (in_i.origin_y),
    .digit_size_i (in_i.digit_size),
    .digit_code_i (in_i.digit_code),
    .column_i     (in_i.column),
    .out_o        (out_o)
  );

endmodule

// File: rtl/ssgcr_checker.sv
// ----------------------------------------------------------------------------
// Seven-segment glyph column raster checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module ssgcr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] pos_x_i,
  input logic [7:0] pos_y_i,
  input logic [7:0] pixel_byte_i,
  input logic       last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Output item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(pos_x_i) && $stable(pos_y_i) && $stable(pixel_byte_i) && $stable(last_i))
    else $error("Output item changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Input accepted again before the column was done.");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("Gap between bytes of one column.");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> !in_ready_i)
    else $error("Input ready while a column is still being emitted.");

endmodule

bind seven_segment_glyph_column_raster_unit ssgcr_checker u_ssgcr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .pos_x_i      (out_o.pos_x),
  .pos_y_i      (out_o.pos_y),
  .pixel_byte_i (out_o.pixel_byte),
  .last_i       (out_o.last)
);
